/* design/tmeb_pkg.sv */
`timescale 1ns / 1ps
package tmeb_pkg;
  localparam int MaxNodesDef = 64;
  localparam int MaxEdgesDef = 256;
  localparam logic [3:0] ShareMax = 4'd15;

  typedef enum logic [2:0] {
    ActAdd = 3'd0, ActBuild = 3'd1, ActLookup = 3'd2, ActRead = 3'd3, ActClear = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    StOk = 3'd0, StRange = 3'd1, StOver = 3'd2, StNotBuilt = 3'd3, StSat = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    SIdle, SAddRd, SAddWr, SBldRd, SBldWr, SLkRd, SLkWait, SRdRd, SRdWait, SRdSh,
    SRdShWait, SClr, SOut
  } state_e;
endpackage

/* design/tmeb_mem.sv */
`timescale 1ns / 1ps
module tmeb_mem import tmeb_pkg::*; #(
  parameter int Depth = 4096,
  parameter int Width = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

/* design/triangle_mesh_edge_builder_top.sv */
`timescale 1ns / 1ps
// channel | valid        | ready        | payload
// in      | in_valid_i   | in_ready_o   | action_i vertex_a_i vertex_b_i vertex_c_i edge_query_i
// out     | out_valid_o  | out_ready_i  | edge_number_o share_count_o end_low_o end_high_o
//         |              |              | edge_total_o status_o
// cfg     | cfg_we_i     | -            | cfg_data_i
// One item at a time. Add: 6 read/write pairs on the share memory, with the write
// skipped for each diagonal pair. Lookup reads the share and number memories; read edge
// reads the ends table, then the share memory; a rejected item goes straight to SOut.
// Build clears the number memory, then reads and numbers each cell above the diagonal.
// Clear sweeps both tables. After reset a clearing pass runs; in_ready_o is low.
// The input opens once the FSM idles, even while a beat waits in the output register;
// the next finished item then holds in SOut until that beat leaves.
module triangle_mesh_edge_builder_top import tmeb_pkg::*; #(
  parameter int MaxNodes = MaxNodesDef,
  parameter int MaxEdges = MaxEdgesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] action_i,
  input  logic [5:0] vertex_a_i,
  input  logic [5:0] vertex_b_i,
  input  logic [5:0] vertex_c_i,
  input  logic [8:0] edge_query_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [8:0] edge_number_o,
  output logic [3:0] share_count_o,
  output logic [5:0] end_low_o,
  output logic [5:0] end_high_o,
  output logic [8:0] edge_total_o,
  output logic [2:0] status_o
);
  localparam int NB = $clog2(MaxNodes);
  localparam int AB = 2 * NB;
  localparam int EB = $clog2(MaxEdges);
  localparam int CB = NB + 1;
  localparam int ECB = $clog2(MaxEdges + 1);

  state_e state_q, state_d;
  logic [6:0] ncfg_q;
  logic [CB-1:0] n_eff;
  logic [5:0] va_q, vb_q, vc_q;
  logic [8:0] query_q;
  logic [2:0] act_q;
  logic [2:0] pair_q, pair_d;
  logic [NB-1:0] ri_q, ri_d, cj_q, cj_d;
  logic [AB-1:0] clr_q, clr_d;
  logic [ECB-1:0] e_q, e_d;
  logic over_q, over_d;
  logic [8:0] found_q, found_d;
  logic built_q, built_d;
  logic [8:0] num_q, num_d;
  logic [3:0] sh_q, sh_d;
  logic [5:0] lo_q, lo_d, hi_q, hi_d;
  logic [2:0] st_q, st_d;
  logic ov_q, ov_d;
  logic out_ld;
  logic [8:0] onum_q, otot_q;
  logic [3:0] osh_q;
  logic [5:0] olo_q, ohi_q;
  logic [2:0] ost_q;

  logic s_we, n_we, e_we;
  logic [AB-1:0] s_wa, s_ra, n_wa, n_ra;
  logic [3:0] s_wd, s_rd;
  logic [8:0] n_wd, n_rd;
  logic [EB-1:0] e_wa, e_ra;
  logic [2*NB-1:0] e_rd;

  tmeb_mem #(.Depth(MaxNodes*MaxNodes), .Width(4)) u_share (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd));
  // number table: builds write only the upper half (row < column); clearing zeroes all of it
  tmeb_mem #(.Depth(MaxNodes*MaxNodes), .Width(9)) u_num (
    .clk_i, .we_i(n_we), .waddr_i(n_wa), .wdata_i(n_wd), .raddr_i(n_ra), .rdata_o(n_rd));
  tmeb_mem #(.Depth(MaxEdges), .Width(2*NB)) u_ends (
    .clk_i, .we_i(e_we), .waddr_i(e_wa), .wdata_i({ri_q, cj_q}), .raddr_i(e_ra),
    .rdata_o(e_rd));

  logic boot_done_q;

  assign n_eff = (ncfg_q > 7'(MaxNodes)) ? CB'(MaxNodes) : CB'(ncfg_q);

  logic [5:0] pu, pv;
  always_comb begin
    case (pair_q)
      3'd0: begin pu = va_q; pv = vb_q; end
      3'd1: begin pu = va_q; pv = vc_q; end
      3'd2: begin pu = vb_q; pv = va_q; end
      3'd3: begin pu = vb_q; pv = vc_q; end
      3'd4: begin pu = vc_q; pv = va_q; end
      default: begin pu = vc_q; pv = vb_q; end
    endcase
  end

  logic rng_in3, rng_in2;
  assign rng_in2 = (CB'(vertex_a_i) < n_eff) && (CB'(vertex_b_i) < n_eff)
                   && (vertex_a_i < 6'(MaxNodes - 1) + 6'd1 || MaxNodes > 63);
  assign rng_in3 = rng_in2 && (CB'(vertex_c_i) < n_eff);

  assign in_ready_o = (state_q == SIdle);
  assign out_valid_o = ov_q;
  assign edge_number_o = onum_q;
  assign share_count_o = osh_q;
  assign end_low_o = olo_q;
  assign end_high_o = ohi_q;
  assign edge_total_o = otot_q;
  assign status_o = ost_q;

  logic last_col, last_row;
  assign last_col = (CB'(cj_q) + 1'b1 >= n_eff);
  assign last_row = (CB'(ri_q) + 2'd2 >= n_eff);

  always_comb begin
    state_d = state_q; pair_d = pair_q; ri_d = ri_q; cj_d = cj_q; clr_d = clr_q;
    e_d = e_q; over_d = over_q; found_d = found_q; built_d = built_q;
    num_d = num_q; sh_d = sh_q; lo_d = lo_q; hi_d = hi_q; st_d = st_q;
    ov_d = ov_q && !out_ready_i;
    out_ld = 1'b0;
    s_we = 1'b0; s_wa = {pu[NB-1:0], pv[NB-1:0]}; s_wd = s_rd + 4'd1;
    s_ra = {pu[NB-1:0], pv[NB-1:0]};
    n_we = 1'b0; n_wa = {ri_q, cj_q};
    n_wd = 9'(e_q) + 9'd1;
    // pair order normalized onto the written half
    n_ra = (va_q < vb_q) ? {va_q[NB-1:0], vb_q[NB-1:0]} : {vb_q[NB-1:0], va_q[NB-1:0]};
    e_we = 1'b0; e_wa = e_q[EB-1:0]; e_ra = EB'(query_q - 9'd1);
    case (state_q)
      SIdle: if (in_valid_i && in_ready_o) begin
        num_d = '0; sh_d = '0; lo_d = '0; hi_d = '0; st_d = StOk;
        pair_d = '0;
        case (action_i)
          ActAdd: if (rng_in3) state_d = SAddRd;
                  else begin st_d = StRange; state_d = SOut; end
          ActBuild: begin
            ri_d = '0; cj_d = NB'(1); e_d = '0; over_d = 1'b0;
            clr_d = '0; state_d = SClr;
          end
          ActLookup: if (rng_in2) state_d = SLkRd;
                     else begin st_d = StRange; state_d = SOut; end
          ActRead:
            if (!built_q) begin st_d = StNotBuilt; state_d = SOut; end
            else if (edge_query_i == 9'd0 || edge_query_i > found_q) begin
              st_d = StRange; state_d = SOut;
            end else state_d = SRdRd;
          ActClear: begin clr_d = '0; found_d = '0; built_d = 1'b0; state_d = SClr; end
          default: begin st_d = StRange; state_d = SOut; end
        endcase
      end
      SAddRd: begin
        if (pu == pv) begin
          if (pair_q == 3'd5) begin built_d = 1'b0; state_d = SOut; end
          else pair_d = pair_q + 3'd1;
        end else state_d = SAddWr;
      end
      SAddWr: begin
        if (s_rd >= ShareMax) st_d = StSat;
        else s_we = 1'b1;
        if (pair_q == 3'd5) begin built_d = 1'b0; state_d = SOut; end
        else begin pair_d = pair_q + 3'd1; state_d = SAddRd; end
      end
      SClr: begin
        s_we = (act_q == ActClear); s_wa = clr_q; s_wd = '0;
        n_we = 1'b1; n_wa = clr_q; n_wd = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          if (act_q == ActBuild && n_eff > CB'(1)) state_d = SBldRd;
          else if (act_q == ActBuild) begin
            found_d = '0; built_d = 1'b1; state_d = SOut;
          end else state_d = SOut;
        end
      end
      SBldRd: begin s_ra = {ri_q, cj_q}; state_d = SBldWr; end
      SBldWr: begin
        if (s_rd != 4'd0) begin
          if (e_q >= ECB'(MaxEdges)) over_d = 1'b1;
          else begin
            e_we = 1'b1; n_we = 1'b1; e_d = e_q + 1'b1;
          end
        end
        if (last_col) begin
          if (last_row) begin
            found_d = 9'(e_d); built_d = 1'b1;
            st_d = (over_d) ? StOver : StOk; state_d = SOut;
          end else begin
            ri_d = ri_q + 1'b1; cj_d = ri_q + NB'(2); state_d = SBldRd;
          end
        end else begin cj_d = cj_q + 1'b1; state_d = SBldRd; end
      end
      SLkRd: begin s_ra = {va_q[NB-1:0], vb_q[NB-1:0]}; state_d = SLkWait; end
      SLkWait: begin
        sh_d = s_rd;
        if (built_q) num_d = n_rd; else st_d = StNotBuilt;
        state_d = SOut;
      end
      SRdRd: state_d = SRdWait;
      SRdWait: begin
        lo_d = 6'(e_rd[2*NB-1:NB]); hi_d = 6'(e_rd[NB-1:0]); num_d = query_q;
        state_d = SRdSh;
      end
      SRdSh: begin s_ra = {lo_q[NB-1:0], hi_q[NB-1:0]}; state_d = SRdShWait; end
      SRdShWait: begin sh_d = s_rd; state_d = SOut; end
      // hold until the output register is free
      SOut: if (!ov_q || out_ready_i) begin
        out_ld = 1'b1; ov_d = 1'b1; state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr; act_q <= ActClear; clr_q <= '0; ov_q <= 1'b0;
      found_q <= '0; built_q <= 1'b0; ncfg_q <= 7'd64;
      pair_q <= '0; ri_q <= '0; cj_q <= '0; e_q <= '0; over_q <= 1'b0;
      boot_done_q <= 1'b0;
    end else begin
      // the reset sweep ends in SOut; swallow that beat
      if (state_q == SClr && clr_q == '1 && boot_done_q == 1'b0) begin
        state_q <= SIdle; boot_done_q <= 1'b1; ov_q <= 1'b0;
      end else begin
        state_q <= state_d; ov_q <= ov_d;
      end
      clr_q <= clr_d; found_q <= found_d; built_q <= built_d;
      pair_q <= pair_d; ri_q <= ri_d; cj_q <= cj_d; e_q <= e_d; over_q <= over_d;
      if (cfg_we_i) ncfg_q <= cfg_data_i;
      if (in_valid_i && in_ready_o) act_q <= action_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      va_q <= vertex_a_i; vb_q <= vertex_b_i; vc_q <= vertex_c_i; query_q <= edge_query_i;
    end
    num_q <= num_d; sh_q <= sh_d; lo_q <= lo_d; hi_q <= hi_d; st_q <= st_d;
    if (out_ld) begin
      onum_q <= num_q; osh_q <= sh_q; olo_q <= lo_q; ohi_q <= hi_q;
      otot_q <= found_q; ost_q <= st_q;
    end
  end
endmodule

/* design/tmeb_checker.sv */
`timescale 1ns / 1ps
module tmeb_checker import tmeb_pkg::*; (
  input logic clk_i, input logic rst_ni,
  input logic in_valid_i, input logic in_ready_o,
  input logic out_valid_o, input logic out_ready_i,
  input logic [2:0] status_o, input logic [3:0] share_count_o,
  input logic [8:0] edge_number_o
);
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("second beat taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= StSat) else $error("bad status");
  a_nb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StNotBuilt |-> edge_number_o == 9'd0)
    else $error("number while not built");
endmodule

bind triangle_mesh_edge_builder_top tmeb_checker u_chk (.*);

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import tmeb_pkg::*;

  typedef struct packed {
    logic [8:0] number;
    logic [3:0] shares;
    logic [5:0] lo;
    logic [5:0] hi;
    logic [8:0] total;
    logic [2:0] status;
  } edge_reply_t;

  class edge_table_scoreboard;
    logic [3:0]  shares [64][64];
    logic [8:0]  numbers [64][64];
    logic [5:0]  end_lo [256];
    logic [5:0]  end_hi [256];
    int          found;
    bit          built;
    logic [6:0]  nodes;
    edge_reply_t pending [$];
    int          mismatches;
    int          replies;
    int          adds, builds, overflows, saturations, range_errs;

    function new();
      wipe();
      nodes = 7'd64;
    endfunction

    function void wipe();
      foreach (shares[i, j]) begin
        shares[i][j] = '0;
        numbers[i][j] = '0;
      end
      found = 0;
      built = 0;
    endfunction

    function int live_nodes();
      return (nodes < 64) ? nodes : 64;
    endfunction

    function void note_item(logic [2:0] act, logic [5:0] a, logic [5:0] b, logic [5:0] c,
                            logic [8:0] query);
      edge_reply_t r;
      logic [5:0] v [3];
      int n, e;
      bit over;
      r = '0;
      n = live_nodes();
      v[0] = a; v[1] = b; v[2] = c;
      case (act)
        ActAdd: begin
          adds++;
          if (a >= n || b >= n || c >= n) begin
            r.status = StRange;
          end else begin
            for (int i = 0; i < 3; i++)
              for (int j = 0; j < 3; j++) begin
                if (v[i] == v[j]) continue;
                if (shares[v[i]][v[j]] == ShareMax) r.status = StSat;
                else shares[v[i]][v[j]]++;
              end
            built = 0;
          end
          if (r.status == StSat) saturations++;
        end
        ActBuild: begin
          builds++;
          e = 0;
          over = 0;
          foreach (numbers[i, j]) numbers[i][j] = '0;
          for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++) begin
              if (shares[i][j] == 0) continue;
              if (e >= 256) begin
                over = 1;
                continue;
              end
              end_lo[e] = 6'(i);
              end_hi[e] = 6'(j);
              e++;
              numbers[i][j] = 9'(e);
              numbers[j][i] = 9'(e);
            end
          found = e;
          built = 1;
          r.status = over ? StOver : StOk;
          if (over) overflows++;
        end
        ActLookup: begin
          if (a >= n || b >= n) begin
            r.status = StRange;
          end else begin
            r.shares = shares[a][b];
            if (built) r.number = numbers[a][b];
            else r.status = StNotBuilt;
          end
        end
        ActRead: begin
          if (!built) r.status = StNotBuilt;
          else if (query == 0 || query > found) r.status = StRange;
          else begin
            r.lo = end_lo[query - 1];
            r.hi = end_hi[query - 1];
            r.number = query;
            r.shares = shares[r.lo][r.hi];
          end
        end
        ActClear: wipe();
        default: r.status = StRange;
      endcase
      if (r.status == StRange) range_errs++;
      r.total = 9'(found);
      pending.insert(pending.size(), r);
    endfunction

    function void check_reply(edge_reply_t got);
      edge_reply_t want;
      replies++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result beat with nothing expected: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: expected %p, got %p", replies, want, got);
      end
    endfunction
  endclass

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       cfg_we_i = 0;
  logic [6:0] cfg_data_i = '0;
  logic       in_valid_i = 0;
  logic       in_ready_o;
  logic [2:0] action_i = '0;
  logic [5:0] vertex_a_i = '0, vertex_b_i = '0, vertex_c_i = '0;
  logic [8:0] edge_query_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 0;
  logic [8:0] edge_number_o, edge_total_o;
  logic [3:0] share_count_o;
  logic [5:0] end_low_o, end_high_o;
  logic [2:0] status_o;

  edge_table_scoreboard sb = new();
  int  burst_left = 0;
  bit  hold_req = 0;
  int  items_sent = 0;

  triangle_mesh_edge_builder_top dut (.*);

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  // outputs are stable at the falling edge; a beat seen here lands on the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_reply('{edge_number_o, share_count_o, end_low_o, end_high_o,
                       edge_total_o, status_o});
  end

  initial begin
    int mode, span;
    @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      repeat (span) begin
        if (hold_req) begin
          out_ready_i <= 0;
          repeat (400) @(posedge clk_i);
          hold_req = 0;
        end
        case (mode)
          0, 1: out_ready_i <= 1;
          2: out_ready_i <= $urandom_range(0, 1);
          default: out_ready_i <= ($urandom_range(0, 9) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end

  // called just after a rising edge; returns just after the edge that took the beat
  task automatic send_item(logic [2:0] act, logic [5:0] a, logic [5:0] b, logic [5:0] c,
                           logic [8:0] query);
    bit taken;
    if (burst_left == 0) begin
      if ($urandom_range(0, 1)) begin
        in_valid_i <= 0;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 25);
    end
    in_valid_i <= 1;
    action_i <= act;
    vertex_a_i <= a;
    vertex_b_i <= b;
    vertex_c_i <= c;
    edge_query_i <= query;
    taken = 0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready_o;
      if (taken) sb.note_item(act, a, b, c, query);
      @(posedge clk_i);
    end
    burst_left--;
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_nodes(logic [6:0] val);
    cfg_we_i <= 1;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
    sb.nodes = val;
  endtask

  function automatic logic [5:0] pick_vertex();
    int n;
    n = sb.live_nodes();
    if (n > 0 && $urandom_range(0, 99) < 88) return 6'($urandom_range(0, n - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic random_item();
    int r, n, build_cut;
    logic [2:0] act;
    logic [8:0] q;
    n = sb.live_nodes();
    build_cut = (n >= 32) ? 89 : 94;
    r = $urandom_range(0, 99);
    if (r < 55) act = ActAdd;
    else if (r < 75) act = ActLookup;
    else if (r < 87) act = ActRead;
    else if (r < build_cut) act = ActBuild;
    else if (r < 96) act = ActClear;
    else if (r < 98) act = 3'($urandom_range(5, 7));
    else act = ActAdd;
    if ($urandom_range(0, 4) != 0) q = 9'($urandom_range(0, sb.found + 1));
    else q = 9'($urandom_range(0, 511));
    send_item(act, pick_vertex(), pick_vertex(), pick_vertex(), q);
  endtask

  initial begin
    logic [6:0] plan [];
    plan = '{7'd3, 7'd0, 7'd1, 7'd127, 7'd12, 7'd6, 7'd64, 7'd9, 7'd2, 7'd5, 7'd20};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    set_nodes(7'd64);

    // directed: not-built queries, extremes, repeated vertex, unknown codes
    send_item(ActLookup, 6'd0, 6'd63, 6'd0, 9'd1);
    send_item(ActRead, 6'd0, 6'd0, 6'd0, 9'd1);
    send_item(ActAdd, 6'd0, 6'd1, 6'd63, 9'd0);
    send_item(ActAdd, 6'd5, 6'd5, 6'd6, 9'd0);
    send_item(ActAdd, 6'd63, 6'd63, 6'd63, 9'd511);
    send_item(3'd5, 6'd63, 6'd63, 6'd63, 9'd511);
    send_item(3'd7, 6'd0, 6'd0, 6'd0, 9'd0);
    send_item(ActBuild, 6'd0, 6'd0, 6'd0, 9'd0);
    send_item(ActLookup, 6'd63, 6'd0, 6'd0, 9'd0);
    send_item(ActLookup, 6'd0, 6'd63, 6'd0, 9'd0);
    send_item(ActLookup, 6'd5, 6'd5, 6'd0, 9'd0);
    send_item(ActRead, 6'd0, 6'd0, 6'd0, 9'd1);
    send_item(ActRead, 6'd0, 6'd0, 6'd0, 9'd4);
    send_item(ActRead, 6'd0, 6'd0, 6'd0, 9'd0);
    send_item(ActRead, 6'd0, 6'd0, 6'd0, 9'd511);
    send_item(ActAdd, 6'd1, 6'd2, 6'd3, 9'd0);
    send_item(ActLookup, 6'd1, 6'd2, 6'd0, 9'd0);
    send_item(ActClear, 6'd0, 6'd0, 6'd0, 9'd0);
    send_item(ActLookup, 6'd0, 6'd1, 6'd0, 9'd0);
    drain();

    // dense mesh on all nodes so the build runs out of edge numbers
    repeat (110) send_item(ActAdd, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                           6'($urandom_range(0, 63)), 9'd0);
    send_item(ActBuild, 6'd0, 6'd0, 6'd0, 9'd0);
    repeat (30) random_item();
    drain();

    foreach (plan[p]) begin
      set_nodes(plan[p]);
      for (int k = 0; k < 108; k++) begin
        if (p == 1 && k == 10) hold_req = 1;
        if (p == 4 && k == 50) drain();
        random_item();
      end
      drain();
    end
    set_nodes(7'd64);

    drain();
    repeat (100) @(posedge clk_i);
    $display("Covered %0d items: %0d adds, %0d builds (%0d overflowed), %0d saturated adds,",
             items_sent, sb.adds, sb.builds, sb.overflows, sb.saturations);
    $display("%0d range errors, %0d result beats checked, %0d mismatches.",
             sb.range_errs, sb.replies, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* triangle_mesh_edge_builder_top.f */
design/tmeb_pkg.sv
design/tmeb_mem.sv
design/triangle_mesh_edge_builder_top.sv
design/tmeb_checker.sv
dv/tb.sv
